// ===== sv/rsst_pkg.sv =====
// Shared widths, codes and types of the range spread segment tree.
package rsst_pkg;

  localparam int unsigned LEAVES = 1024;
  localparam int LEAF_W = $clog2(LEAVES);
  localparam int NODE_W = LEAF_W + 1;
  localparam int IDX_W = NODE_W + 1;
  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int IN_DATA_W = ((2 * POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = VAL_W;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic signed [VAL_W-1:0] mx;
    logic signed [VAL_W-1:0] mn;
  } node_t;

  typedef struct packed {
    logic en;
    logic [NODE_W-1:0] addr;
    node_t data;
  } ram_wr_t;

  typedef struct packed {
    logic [NODE_W-1:0] addr_a;
    logic [NODE_W-1:0] addr_b;
  } ram_rd_t;

  typedef struct packed {
    logic valid;
    logic [VAL_W-1:0] spread;
    logic err;
  } result_t;

endpackage

// ===== sv/rsst_node_ram.sv =====
// Node store: max/min pairs, one write port, two registered read ports.
module rsst_node_ram (
  input  logic              clk_i,
  input  rsst_pkg::ram_wr_t wr_i,
  input  rsst_pkg::ram_rd_t rd_i,
  output rsst_pkg::node_t   rd_a_o,
  output rsst_pkg::node_t   rd_b_o
);

  rsst_pkg::node_t mem_q [2**rsst_pkg::NODE_W];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_o <= mem_q[rd_i.addr_a];
    rd_b_o <= mem_q[rd_i.addr_b];
  end

endmodule

// ===== sv/rsst_ctrl.sv =====
// Sequencer: clear pass, leaf update up to the root, range fold for queries.
module rsst_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_cmd_i,
  input  logic [rsst_pkg::POS_W-1:0]    in_first_i,
  input  logic [rsst_pkg::POS_W-1:0]    in_last_i,
  input  logic [rsst_pkg::VAL_W-1:0]    in_value_i,
  input  logic                          out_free_i,
  output rsst_pkg::result_t             res_o,
  output rsst_pkg::ram_wr_t             ram_wr_o,
  output rsst_pkg::ram_rd_t             ram_rd_o,
  input  rsst_pkg::node_t               rd_a_i,
  input  rsst_pkg::node_t               rd_b_i
);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_URD   = 3'd2;
  localparam logic [2:0] ST_UWR   = 3'd3;
  localparam logic [2:0] ST_QRD   = 3'd4;
  localparam logic [2:0] ST_QFOLD = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic signed [rsst_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(rsst_pkg::VAL_W-1){1'b0}}};
  localparam logic signed [rsst_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(rsst_pkg::VAL_W-1){1'b1}}};

  logic [2:0]                         state_q, state_d;
  logic [rsst_pkg::NODE_W-1:0]        clr_q, clr_d;
  logic [rsst_pkg::NODE_W-1:0]        cur_q, cur_d;
  logic [rsst_pkg::IDX_W-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic signed [rsst_pkg::VAL_W-1:0]  mx_q, mx_d, mn_q, mn_d;
  logic                               err_q, err_d;

  logic [rsst_pkg::IDX_W-1:0]         hi_m1;
  logic [rsst_pkg::IDX_W-1:0]         lo_step, hi_step;
  logic [rsst_pkg::NODE_W-1:0]        parent;
  logic signed [rsst_pkg::VAL_W-1:0]  fmx, fmn;
  logic                               upd_ok, qry_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign hi_m1 = hi_q - rsst_pkg::IDX_W'(1);
  assign parent = cur_q >> 1;
  assign upd_ok = (32'(in_first_i) < rsst_pkg::LEAVES);
  assign qry_ok = (in_first_i <= in_last_i) && (32'(in_last_i) < rsst_pkg::LEAVES);

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    cur_d = cur_q;
    lo_d = lo_q;
    hi_d = hi_q;
    mx_d = mx_q;
    mn_d = mn_q;
    err_d = err_q;
    ram_wr_o = '0;
    ram_rd_o = '0;
    res_o = '0;
    fmx = mx_q;
    fmn = mn_q;
    lo_step = lo_q;
    hi_step = hi_q;
    case (state_q)
      ST_CLR: begin
        ram_wr_o.en = 1'b1;
        ram_wr_o.addr = clr_q;
        clr_d = clr_q + rsst_pkg::NODE_W'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == rsst_pkg::CMD_UPDATE) begin
            if (upd_ok) begin
              cur_d = rsst_pkg::NODE_W'(rsst_pkg::LEAVES) + rsst_pkg::NODE_W'(in_first_i);
              ram_wr_o.en = 1'b1;
              ram_wr_o.addr = cur_d;
              ram_wr_o.data.mx = $signed(in_value_i);
              ram_wr_o.data.mn = $signed(in_value_i);
              mx_d = $signed(in_value_i);
              mn_d = $signed(in_value_i);
              state_d = ST_URD;
            end
          end else if (qry_ok) begin
            lo_d = rsst_pkg::IDX_W'(rsst_pkg::LEAVES) + rsst_pkg::IDX_W'(in_first_i);
            hi_d = rsst_pkg::IDX_W'(rsst_pkg::LEAVES) + rsst_pkg::IDX_W'(in_last_i)
                   + rsst_pkg::IDX_W'(1);
            mx_d = VAL_MIN;
            mn_d = VAL_MAX;
            err_d = 1'b0;
            state_d = ST_QRD;
          end else begin
            err_d = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_URD: begin
        ram_rd_o.addr_a = cur_q ^ rsst_pkg::NODE_W'(1);
        state_d = ST_UWR;
      end
      ST_UWR: begin
        if ($signed(rd_a_i.mx) > mx_q) fmx = $signed(rd_a_i.mx);
        if ($signed(rd_a_i.mn) < mn_q) fmn = $signed(rd_a_i.mn);
        ram_wr_o.en = 1'b1;
        ram_wr_o.addr = parent;
        ram_wr_o.data.mx = fmx;
        ram_wr_o.data.mn = fmn;
        mx_d = fmx;
        mn_d = fmn;
        cur_d = parent;
        state_d = (parent == rsst_pkg::NODE_W'(1)) ? ST_IDLE : ST_URD;
      end
      ST_QRD: begin
        if (lo_q < hi_q) begin
          ram_rd_o.addr_a = lo_q[rsst_pkg::NODE_W-1:0];
          ram_rd_o.addr_b = hi_m1[rsst_pkg::NODE_W-1:0];
          state_d = ST_QFOLD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_QFOLD: begin
        // odd left bound and odd right bound each fold one node
        if (lo_q[0]) begin
          if ($signed(rd_a_i.mx) > fmx) fmx = $signed(rd_a_i.mx);
          if ($signed(rd_a_i.mn) < fmn) fmn = $signed(rd_a_i.mn);
          lo_step = lo_q + rsst_pkg::IDX_W'(1);
        end
        if (hi_q[0]) begin
          if ($signed(rd_b_i.mx) > fmx) fmx = $signed(rd_b_i.mx);
          if ($signed(rd_b_i.mn) < fmn) fmn = $signed(rd_b_i.mn);
          hi_step = hi_m1;
        end
        mx_d = fmx;
        mn_d = fmn;
        lo_d = lo_step >> 1;
        hi_d = hi_step >> 1;
        state_d = ST_QRD;
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.err = err_q;
          res_o.spread = err_q ? '0 : ($unsigned(mx_q) - $unsigned(mn_q));
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    mx_q <= mx_d;
    mn_q <= mn_d;
    err_q <= err_d;
  end

endmodule

// ===== sv/range_spread_segment_tree_core.sv =====
// Top level of the range spread segment tree with its output register.
//
// channel  dir  tdata                               tuser
// s_axis   in   first[9:0] last[19:10] val[51:20]   command (0 update, 1 query)
// m_axis   out  spread[31:0]                        error
//
// Update: leaf write, then one tree level per read/write pair.
// Query: two node reads per level.
// Bad query range: error result. Update with no result: no output word.
// After reset a clearing pass zeroes all 2*LEAVES nodes, tready low.
// A pending output word does not stall updates; a query waits for the output slot.
module range_spread_segment_tree_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rsst_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // first, last, new_value
  input  logic                             s_axis_tuser,  // command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rsst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // spread
  output logic                             m_axis_tuser   // error
);

  rsst_pkg::ram_wr_t ram_wr;
  rsst_pkg::ram_rd_t ram_rd;
  rsst_pkg::node_t   rd_a, rd_b;
  rsst_pkg::result_t res;

  logic                             m_valid_q, m_valid_d;
  logic [rsst_pkg::OUT_DATA_W-1:0]  m_data_q, m_data_d;
  logic                             m_err_q, m_err_d;
  logic                             out_free;

  assign out_free = !m_valid_q || m_axis_tready;

  rsst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_first_i (s_axis_tdata[rsst_pkg::POS_W-1:0]),
    .in_last_i  (s_axis_tdata[2*rsst_pkg::POS_W-1:rsst_pkg::POS_W]),
    .in_value_i (s_axis_tdata[2*rsst_pkg::POS_W+rsst_pkg::VAL_W-1:2*rsst_pkg::POS_W]),
    .out_free_i (out_free),
    .res_o      (res),
    .ram_wr_o   (ram_wr),
    .ram_rd_o   (ram_rd),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b)
  );

  rsst_node_ram u_ram (
    .clk_i  (clk_i),
    .wr_i   (ram_wr),
    .rd_i   (ram_rd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d = m_data_q;
    m_err_d = m_err_q;
    if (res.valid) begin
      m_valid_d = 1'b1;
      m_data_d = res.spread;
      m_err_d = res.err;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_err_q <= m_err_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;
  assign m_axis_tuser = m_err_q;

endmodule

// ===== sv/rsst_checker.sv =====
// Port-level checks of the range spread segment tree, bound to the top level.
module rsst_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [rsst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rsst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);

  logic in_acc, busy_item;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign busy_item = (s_axis_tuser == rsst_pkg::CMD_QUERY)
      || (32'(s_axis_tdata[rsst_pkg::POS_W-1:0]) < rsst_pkg::LEAVES);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error word with nonzero spread");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_acc && busy_item |=> !s_axis_tready)
    else $error("input taken while previous word still in work");

endmodule

bind range_spread_segment_tree_core rsst_checker u_rsst_checker (.*);
